### hdl/pts_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the packed table with swap-remove.
// No dependencies; every other file imports this package.
package pts_pkg;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_LOOKUP = 2'd2;
	localparam logic [1:0] CMD_CLEAR  = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_DUPLICATE = 2'd3;

	typedef struct packed {
		logic [1:0]  command;
		logic [63:0] key;
		logic [63:0] payload;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  slot_index;
		logic [63:0] entry_data;
		logic [6:0]  count_after;
	} out_item_t;

	// Broadcast controls from the sequencer to every cell.
	typedef struct packed {
		logic match_en;
		logic ins_en;
		logic mov_en;
	} cell_ctl_t;

	typedef enum logic [3:0] {
		S_IDLE    = 4'b0001,
		S_MATCH   = 4'b0010,
		S_RESOLVE = 4'b0100,
		S_DONE    = 4'b1000
	} state_t;

endpackage

### hdl/pts_cell.sv
`timescale 1ns / 1ps
// One slot of the packed table: key, payload, key match and last-slot flags.
// Depends on pts_pkg.
module pts_cell #(
	parameter int IDX_W = 6,
	parameter int CNT_W = 7,
	parameter int PAYLOAD_WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [IDX_W-1:0]         slot_id,
	input  logic [CNT_W-1:0]         count,
	input  logic [63:0]              probe_key,
	input  pts_pkg::cell_ctl_t       ctl,
	input  logic [63:0]              wr_key,
	input  logic [PAYLOAD_WIDTH-1:0] wr_payload,
	output logic                     hit_q,
	output logic                     last_q,
	output logic [63:0]              key_q,
	output logic [PAYLOAD_WIDTH-1:0] payload_q
);
	import pts_pkg::*;

	logic live;
	logic is_last;
	logic wr;

	assign live    = CNT_W'(slot_id) < count;
	assign is_last = CNT_W'(slot_id) == (count - CNT_W'(1));
	// append lands at slot == count; a move lands on the matched hole
	assign wr = (ctl.ins_en && (count[IDX_W-1:0] == slot_id)) || (ctl.mov_en && hit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			last_q <= 1'b0;
		end else if (ctl.match_en) begin
			hit_q  <= live && (key_q == probe_key);
			last_q <= is_last;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			key_q     <= wr_key;
			payload_q <= wr_payload;
		end
	end

endmodule

### hdl/pts_gather.sv
`timescale 1ns / 1ps
// One-hot gather: OR of the words whose select bit is set.
// Depends on pts_pkg.
module pts_gather #(
	parameter int N = 64,
	parameter int W = 64
) (
	input  logic [N-1:0]        sel,
	input  logic [N-1:0][W-1:0] words,
	output logic [W-1:0]        word
);
	import pts_pkg::*;

	always_comb begin
		word = '0;
		for (int i = 0; i < N; i++) begin
			word = word | (words[i] & {W{sel[i]}});
		end
	end

endmodule

### hdl/packed_table_swap_remove.sv
`timescale 1ns / 1ps
// Top level of the packed keyed table with swap-remove: sequencer, cell row
// and gathers. Depends on pts_pkg, pts_cell and pts_gather.
//
//   channel | signals                     | payload type
//   --------+-----------------------------+-------------------
//   command | cmd_valid / cmd_ready / cmd | pts_pkg::in_item_t
//   result  | res_valid / res_ready / res | pts_pkg::out_item_t
//
// One transaction in gives one transaction out. After acceptance an item
// passes through the cell row (parallel key compare, registered per
// cell), the resolve step (gather of the hit and last slots, table write)
// and the handoff of its result to the output register; the next command
// is accepted only after that handoff.
// A result waiting in the output register does not block the next command;
// only the handoff cycle waits for the output register to free up.
// Reset clears the entry count and the control; slot contents stay unknown
// and are never read before written, since only live slots match.
module packed_table_swap_remove #(
	parameter int CAPACITY = 64,
	parameter int PAYLOAD_WIDTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  pts_pkg::in_item_t   cmd,
	output logic                res_valid,
	input  logic                res_ready,
	output pts_pkg::out_item_t  res
);
	import pts_pkg::*;

	localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int SLOT_W = (IDX_W > 6) ? IDX_W : 6;
	localparam int CNTO_W = (CNT_W > 7) ? CNT_W : 7;

	state_t                    state_q;
	in_item_t                  item_q;
	logic [CNT_W-1:0]          count_q;
	out_item_t                 result_q;
	logic                      res_valid_q;
	out_item_t                 res_q;

	cell_ctl_t                 ctl;
	logic [63:0]               wr_key;
	logic [PAYLOAD_WIDTH-1:0]  wr_payload;

	logic [CAPACITY-1:0]                    hit_vec;
	logic [CAPACITY-1:0]                    last_vec;
	logic [CAPACITY-1:0][63:0]              key_vec;
	logic [CAPACITY-1:0][PAYLOAD_WIDTH-1:0] pay_vec;
	logic [CAPACITY-1:0][IDX_W-1:0]         id_vec;

	logic [IDX_W-1:0]          hit_idx;
	logic [PAYLOAD_WIDTH-1:0]  hit_payload;
	logic [63:0]               last_key;
	logic [PAYLOAD_WIDTH-1:0]  last_payload;

	logic                      any_hit;
	logic                      full;
	logic [CNT_W-1:0]          count_nxt;
	logic [1:0]                status_nxt;
	logic [IDX_W-1:0]          slot_nxt;
	logic [PAYLOAD_WIDTH-1:0]  data_nxt;
	logic                      ins_go;
	logic                      mov_go;
	logic [SLOT_W-1:0]         slot_ext;
	logic [CNTO_W-1:0]         count_ext;
	logic                      out_free;

	// Cell row: each slot compares its own key and flags whether it is the last one.
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		assign id_vec[g] = IDX_W'(g);

		pts_cell #(
			.IDX_W(IDX_W),
			.CNT_W(CNT_W),
			.PAYLOAD_WIDTH(PAYLOAD_WIDTH)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.slot_id(id_vec[g]),
			.count(count_q),
			.probe_key(item_q.key),
			.ctl(ctl),
			.wr_key(wr_key),
			.wr_payload(wr_payload),
			.hit_q(hit_vec[g]),
			.last_q(last_vec[g]),
			.key_q(key_vec[g]),
			.payload_q(pay_vec[g])
		);
	end

	// Keys are unique among live slots, so at most one hit bit is set.
	pts_gather #(.N(CAPACITY), .W(IDX_W)) u_hit_idx (
		.sel(hit_vec), .words(id_vec), .word(hit_idx)
	);
	pts_gather #(.N(CAPACITY), .W(PAYLOAD_WIDTH)) u_hit_pay (
		.sel(hit_vec), .words(pay_vec), .word(hit_payload)
	);
	pts_gather #(.N(CAPACITY), .W(64)) u_last_key (
		.sel(last_vec), .words(key_vec), .word(last_key)
	);
	pts_gather #(.N(CAPACITY), .W(PAYLOAD_WIDTH)) u_last_pay (
		.sel(last_vec), .words(pay_vec), .word(last_payload)
	);

	assign any_hit = |hit_vec;
	assign full    = count_q == CNT_W'(CAPACITY);

	// Resolve the command from the registered match flags.
	always_comb begin
		count_nxt  = count_q;
		status_nxt = ST_OK;
		slot_nxt   = '0;
		data_nxt   = '0;
		ins_go     = 1'b0;
		mov_go     = 1'b0;
		case (item_q.command)
			CMD_INSERT: begin
				// duplicate check wins over the full check
				if (any_hit) begin
					status_nxt = ST_DUPLICATE;
				end else if (full) begin
					status_nxt = ST_FULL;
				end else begin
					ins_go    = 1'b1;
					slot_nxt  = count_q[IDX_W-1:0];
					count_nxt = count_q + CNT_W'(1);
				end
			end
			CMD_REMOVE: begin
				if (!any_hit) begin
					status_nxt = ST_NOT_FOUND;
				end else begin
					// moving the last slot onto itself is harmless
					mov_go    = 1'b1;
					slot_nxt  = hit_idx;
					count_nxt = count_q - CNT_W'(1);
				end
			end
			CMD_LOOKUP: begin
				if (!any_hit) begin
					status_nxt = ST_NOT_FOUND;
				end else begin
					slot_nxt = hit_idx;
					data_nxt = hit_payload;
				end
			end
			CMD_CLEAR: begin
				count_nxt = '0;
			end
			default: begin
				count_nxt = count_q;
			end
		endcase
	end

	assign ctl.match_en = state_q == S_MATCH;
	assign ctl.ins_en   = (state_q == S_RESOLVE) && ins_go;
	assign ctl.mov_en   = (state_q == S_RESOLVE) && mov_go;
	assign wr_key       = ins_go ? item_q.key : last_key;
	assign wr_payload   = ins_go ? item_q.payload[PAYLOAD_WIDTH-1:0] : last_payload;

	assign slot_ext  = SLOT_W'(slot_nxt);
	assign count_ext = CNTO_W'(count_nxt);
	assign out_free  = !res_valid_q || res_ready;

	assign cmd_ready = state_q == S_IDLE;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Sequencer and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// load a new result, or drop the one just taken
			if ((state_q == S_DONE) && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						state_q <= S_MATCH;
					end
				end
				S_MATCH: begin
					state_q <= S_RESOLVE;
				end
				S_RESOLVE: begin
					count_q <= count_nxt;
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hold the result until the output register frees up
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers: latched command, pending result, output.
	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			item_q <= cmd;
		end
		if (state_q == S_RESOLVE) begin
			result_q.status      <= status_nxt;
			result_q.slot_index  <= slot_ext[5:0];
			result_q.entry_data  <= 64'(data_nxt);
			result_q.count_after <= count_ext[6:0];
		end
		if ((state_q == S_DONE) && out_free) begin
			res_q <= result_q;
		end
	end

endmodule

### hdl/pts_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the packed table, bound to the top level.
// Depends on pts_pkg and packed_table_swap_remove.
module pts_checker #(
	parameter int CAPACITY = 64
) (
	input logic               clk,
	input logic               arst_n,
	input logic               cmd_valid,
	input logic               cmd_ready,
	input pts_pkg::in_item_t  cmd,
	input logic               res_valid,
	input logic               res_ready,
	input pts_pkg::out_item_t res
);
	import pts_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CNTO_W = (CNT_W > 7) ? CNT_W : 7;
	localparam logic [CNTO_W-1:0] CAP_EXT = CNTO_W'(CAPACITY);

	// hold a stalled result
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// a failed command reports no slot and no data
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.status != ST_OK) |-> (res.slot_index == 6'd0)
			&& (res.entry_data == 64'd0))
		else $error("failed command carries slot or data");

	// a full insert reports a full count
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.status == ST_FULL) |-> res.count_after == CAP_EXT[6:0])
		else $error("table full reported below capacity");

	// one transaction at a time: busy right after acceptance
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command accepted back to back");

endmodule

bind packed_table_swap_remove pts_checker #(.CAPACITY(CAPACITY)) u_pts_checker (
	.clk(clk),
	.arst_n(arst_n),
	.cmd_valid(cmd_valid),
	.cmd_ready(cmd_ready),
	.cmd(cmd),
	.res_valid(res_valid),
	.res_ready(res_ready),
	.res(res)
);

### sim/packed_table_swap_remove_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for packed_table_swap_remove: directed rows, then
// segmented random traffic, scored against literal expectations and an in-bench table model.
// Depends on pts_pkg and the packed_table_swap_remove RTL.
module packed_table_swap_remove_test;
	import pts_pkg::*;

	localparam int CAPACITY = 64;
	localparam int PAYLOAD_WIDTH = 64;
	localparam logic [63:0] PAYLOAD_MASK =
		(PAYLOAD_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << PAYLOAD_WIDTH) - 64'd1);
	localparam int RANDOM_ITEMS = 550;
	localparam int QUIET_TAIL = 60;      // last random items run with no idling
	localparam int LONG_HOLD_AFTER = 150; // results seen before the long result stall

	typedef struct {
		in_item_t  stim;
		bit        typed;   // when set, want is the literal expectation
		out_item_t want;
	} table_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cmd_valid = 1'b0;
	logic       cmd_ready;
	in_item_t   cmd = '0;
	logic       res_valid;
	logic       res_ready = 1'b0;
	out_item_t  res;

	// Testbench copy of the table: live entries sit in slots 0 .. live_entries-1.
	logic [63:0] slot_key [CAPACITY];
	logic [63:0] slot_pay [CAPACITY];
	int          live_entries = 0;
	int          peak_entries = 0;
	logic [63:0] last_gone_key = '0;

	out_item_t   pending_results[$];
	table_row_t  directed_rows[$];

	int  fail_count = 0;
	int  commands_sent = 0;
	int  results_seen = 0;
	int  status_seen [4] = '{0, 0, 0, 0};
	bit  quiet_tail = 1'b0;   // no idling on either side
	bit  long_hold_on = 1'b0; // receiver is in its long stall

	packed_table_swap_remove #(
		.CAPACITY(CAPACITY),
		.PAYLOAD_WIDTH(PAYLOAD_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	// 4 ns clock: two ns high, two ns low.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#(2_000_000);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Apply one command to the testbench table and return the result it owes.
	function automatic out_item_t table_apply(in_item_t c);
		out_item_t r;
		int hit;
		r = '0;
		hit = -1;
		for (int i = 0; i < live_entries; i++)
			if (hit < 0 && slot_key[i] == c.key)
				hit = i;
		case (c.command)
		CMD_INSERT: begin
			// Duplicate check wins over the full check.
			if (hit >= 0) begin
				r.status = ST_DUPLICATE;
			end else if (live_entries >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				r.status = ST_OK;
				r.slot_index = live_entries[5:0];
				slot_key[live_entries] = c.key;
				slot_pay[live_entries] = c.payload & PAYLOAD_MASK;
				live_entries++;
			end
		end
		CMD_REMOVE: begin
			if (hit < 0) begin
				r.status = ST_NOT_FOUND;
			end else begin
				r.status = ST_OK;
				r.slot_index = hit[5:0];
				// Swap the last live entry into the hole; a removed tail just drops.
				if (hit != live_entries - 1) begin
					slot_key[hit] = slot_key[live_entries - 1];
					slot_pay[hit] = slot_pay[live_entries - 1];
				end
				live_entries--;
				last_gone_key = c.key;
			end
		end
		CMD_LOOKUP: begin
			if (hit < 0) begin
				r.status = ST_NOT_FOUND;
			end else begin
				r.status = ST_OK;
				r.slot_index = hit[5:0];
				r.entry_data = slot_pay[hit];
			end
		end
		CMD_CLEAR: begin
			if (live_entries > 0)
				last_gone_key = slot_key[0];
			for (int i = 0; i < CAPACITY; i++) begin
				slot_key[i] = '0;
				slot_pay[i] = '0;
			end
			live_entries = 0;
			r.status = ST_OK;
		end
		endcase
		r.count_after = live_entries[6:0];
		if (live_entries > peak_entries)
			peak_entries = live_entries;
		return r;
	endfunction

	// Offer one transaction, hold it until accepted, then log its expectation.
	// A nonzero gap then drops valid, and the gap argument sets how long it stays low.
	task automatic send_command(in_item_t c, bit typed, out_item_t want, int gap);
		out_item_t predicted;
		@(negedge clk);
		cmd_valid <= 1'b1;
		cmd <= c;
		do
			@(posedge clk);
		while (!cmd_ready);
		predicted = table_apply(c);
		pending_results.push_back(typed ? want : predicted);
		commands_sent++;
		if (gap > 0) begin
			@(negedge clk);
			cmd_valid <= 1'b0;
			repeat (gap - 1)
				@(negedge clk);
		end
	endtask

	task automatic add_row(logic [1:0] op, logic [63:0] k, logic [63:0] p, bit typed,
			logic [1:0] st, logic [5:0] slot, logic [63:0] data, logic [6:0] cnt);
		table_row_t row;
		row.stim.command = op;
		row.stim.key = k;
		row.stim.payload = p;
		row.typed = typed;
		row.want.status = st;
		row.want.slot_index = slot;
		row.want.entry_data = data;
		row.want.count_after = cnt;
		directed_rows.push_back(row);
	endtask

	// Result side: drive ready at the falling edge. Random stall bursts, one long
	// stall that lets the block back up into its input, and none in the tail.
	initial begin
		int hold_left;
		bit long_hold_done;
		hold_left = 0;
		long_hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else if (!quiet_tail && !long_hold_done && results_seen >= LONG_HOLD_AFTER)
			begin
				long_hold_done = 1'b1;
				long_hold_on = 1'b1;
				hold_left = $urandom_range(90, 130);
				res_ready <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
				long_hold_on = 1'b0;
				hold_left = $urandom_range(1, 16) - 1;
				res_ready <= 1'b0;
			end else begin
				long_hold_on = 1'b0;
				res_ready <= 1'b1;
			end
		end
	end

	// Score every result transaction against the oldest expectation.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && res_valid && res_ready) begin
			results_seen++;
			status_seen[res.status]++;
			if (pending_results.size() == 0) begin
				$error("unexpected result: status %0d slot %0d data %h count %0d",
					res.status, res.slot_index, res.entry_data, res.count_after);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (res.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, res.status);
					fail_count++;
				end
				if (res.slot_index !== want.slot_index) begin
					$error("slot_index: expected %0d, got %0d",
						want.slot_index, res.slot_index);
					fail_count++;
				end
				if (res.entry_data !== want.entry_data) begin
					$error("entry_data: expected %h, got %h",
						want.entry_data, res.entry_data);
					fail_count++;
				end
				if (res.count_after !== want.count_after) begin
					$error("count_after: expected %0d, got %0d",
						want.count_after, res.count_after);
					fail_count++;
				end
			end
		end
	end

	// Command side: reset, directed rows, then random segments.
	initial begin
		logic [63:0] ones;
		logic [63:0] fives;
		logic [63:0] tens;
		in_item_t    c;
		out_item_t   none;
		int          seg_left;
		int          ins_pct;
		int          dup_pct;
		int          pick;
		int          gap;
		int          sent;

		ones = {64{1'b1}};
		fives = {16{4'h5}};
		tens = {16{4'hA}};
		none = '0;

		// Hold reset, then release it on a falling edge.
		repeat (4)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed rows: empty-table misses, key and payload extremes, duplicate,
		// swap into a hole, removal of the tail slot, clear, payload ignored.
		add_row(CMD_LOOKUP, '0, '0, 1, ST_NOT_FOUND, 0, '0, 0);
		add_row(CMD_REMOVE, ones, ones, 1, ST_NOT_FOUND, 0, '0, 0);
		add_row(CMD_INSERT, '0, ones, 1, ST_OK, 0, '0, 1);
		add_row(CMD_INSERT, ones, '0, 1, ST_OK, 1, '0, 2);
		add_row(CMD_INSERT, '0, fives, 1, ST_DUPLICATE, 0, '0, 2);
		add_row(CMD_LOOKUP, '0, '0, 1, ST_OK, 0, ones, 2);
		add_row(CMD_LOOKUP, ones, tens, 1, ST_OK, 1, '0, 2);
		add_row(CMD_INSERT, fives, tens, 0, ST_OK, 0, '0, 0);
		add_row(CMD_INSERT, tens, fives, 0, ST_OK, 0, '0, 0);
		add_row(CMD_REMOVE, '0, '0, 1, ST_OK, 0, '0, 3);
		add_row(CMD_LOOKUP, tens, '0, 1, ST_OK, 0, fives, 3);
		add_row(CMD_REMOVE, fives, '0, 1, ST_OK, 2, '0, 2);
		add_row(CMD_LOOKUP, fives, '0, 1, ST_NOT_FOUND, 0, '0, 2);
		add_row(CMD_REMOVE, '0, '0, 1, ST_NOT_FOUND, 0, '0, 2);
		add_row(CMD_LOOKUP, ones, '0, 1, ST_OK, 1, '0, 2);
		add_row(CMD_CLEAR, ones, ones, 1, ST_OK, 0, '0, 0);
		add_row(CMD_LOOKUP, ones, '0, 1, ST_NOT_FOUND, 0, '0, 0);
		add_row(CMD_INSERT, 64'd1, 64'h8000_0000_0000_0001, 1, ST_OK, 0, '0, 1);
		add_row(CMD_LOOKUP, 64'd1, ones, 1, ST_OK, 0, 64'h8000_0000_0000_0001, 1);
		add_row(CMD_REMOVE, 64'd1, fives, 1, ST_OK, 0, '0, 0);
		add_row(CMD_CLEAR, '0, '0, 1, ST_OK, 0, '0, 0);

		foreach (directed_rows[i]) begin
			gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 16) : 0;
			send_command(directed_rows[i].stim, directed_rows[i].typed,
				directed_rows[i].want, gap);
		end

		// Random part in segments. The first segment fills the table past
		// capacity; later ones pick a fill, grow, churn or drain mix at random.
		seg_left = 0;
		ins_pct = 0;
		dup_pct = 0;
		for (sent = 0; sent < RANDOM_ITEMS; sent++) begin
			if (seg_left == 0) begin
				pick = (sent == 0) ? 0 : $urandom_range(0, 3);
				case (pick)
				0: begin
					ins_pct = 100;
					dup_pct = 25;
					seg_left = 100;
				end
				1: begin
					ins_pct = 70;
					dup_pct = 10;
					seg_left = $urandom_range(20, 60);
				end
				2: begin
					ins_pct = 40;
					dup_pct = 15;
					seg_left = $urandom_range(20, 60);
				end
				default: begin
					ins_pct = 15;
					dup_pct = 15;
					seg_left = $urandom_range(20, 60);
				end
				endcase
			end
			seg_left--;
			if (sent >= RANDOM_ITEMS - QUIET_TAIL)
				quiet_tail = 1'b1;

			c.payload = rand64();
			pick = $urandom_range(0, 99);
			if (ins_pct < 100 && pick < 2) begin
				c.command = CMD_CLEAR;
				c.key = rand64();
			end else if ($urandom_range(0, 99) < ins_pct) begin
				c.command = CMD_INSERT;
				// Mostly fresh keys; some live keys to provoke duplicates.
				if (live_entries > 0 && $urandom_range(0, 99) < dup_pct)
					c.key = slot_key[$urandom_range(0, live_entries - 1)];
				else if ($urandom_range(0, 31) == 0)
					c.key = $urandom_range(0, 1) ? ones : '0;
				else
					c.key = rand64();
			end else begin
				c.command = $urandom_range(0, 1) ? CMD_REMOVE : CMD_LOOKUP;
				// Aim at live keys most of the time; otherwise a stale or unknown key.
				pick = $urandom_range(0, 99);
				if (live_entries > 0 && pick < 75)
					c.key = slot_key[$urandom_range(0, live_entries - 1)];
				else if (pick < 88)
					c.key = last_gone_key;
				else
					c.key = rand64();
			end

			// Keep offering during the long result stall so the block backs up.
			if (quiet_tail || long_hold_on || $urandom_range(0, 3) != 0)
				gap = 0;
			else
				gap = $urandom_range(1, 16);
			send_command(c, 1'b0, none, gap);
		end

		@(negedge clk);
		cmd_valid <= 1'b0;

		// Drain, then keep watching for any stray result to show up.
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (12)
			@(posedge clk);

		$display("Ran %0d commands (%0d directed), %0d results, table peak %0d of %0d.",
			commands_sent, directed_rows.size(), results_seen, peak_entries, CAPACITY);
		$display("Status mix: ok %0d, not found %0d, full %0d, duplicate %0d.",
			status_seen[ST_OK], status_seen[ST_NOT_FOUND], status_seen[ST_FULL],
			status_seen[ST_DUPLICATE]);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
